// ===== hdl/ena_pkg.sv =====
// Package for the error norm accumulator: payload structs, mode codes, widths.
// No dependencies.
package ena_pkg;

  localparam int DataW  = 32;
  localparam int DiffW  = 33;
  localparam int AccW   = 64;
  localparam int CountW = 17;
  localparam logic [CountW-1:0] MaxPairs = 17'd65536;

  localparam logic [2:0] ModeInvalid = 3'd0;
  localparam logic [2:0] ModeL1      = 3'd1;
  localparam logic [2:0] ModeL2      = 3'd2;
  localparam logic [2:0] ModeLinf    = 3'd3;

  typedef struct packed {
    logic signed [DataW-1:0] first_mean;
    logic signed [DataW-1:0] second_mean;
    logic signed [DataW-1:0] first_kone;
    logic signed [DataW-1:0] second_kone;
    logic signed [DataW-1:0] first_ktwo;
    logic signed [DataW-1:0] second_ktwo;
    logic                    last_item;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0]  mean_error;
    logic [DataW-1:0]  kone_error;
    logic [DataW-1:0]  ktwo_error;
    logic [CountW-1:0] pair_count;
    logic              status;
  } out_item_t;

  // Item after classification: absolute differences, mode snapshot, last flag.
  typedef struct packed {
    logic [DiffW-1:0] d_mean;
    logic [DiffW-1:0] d_kone;
    logic [DiffW-1:0] d_ktwo;
    logic [2:0]       mode;
    logic             last_item;
  } work_t;

endpackage

// ===== hdl/ena_front.sv =====
// Front end: accepts input items, forms absolute differences, queues them.
// Depends on ena_pkg.
module ena_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ena_pkg::in_item_t in_item,
  input  logic [2:0]        mode,
  output logic              q_valid,
  input  logic              q_ready,
  output ena_pkg::work_t    q_item
);

  ena_pkg::work_t fifo [2];
  logic           wptr, rptr;
  logic [1:0]     fill;
  ena_pkg::work_t wr_item;
  logic           push, pop;

  function automatic logic [ena_pkg::DiffW-1:0] absdiff(logic signed [31:0] a,
                                                       logic signed [31:0] b);
    logic signed [ena_pkg::DiffW-1:0] d;
    d = ena_pkg::DiffW'(a) - ena_pkg::DiffW'(b);
    return d[ena_pkg::DiffW-1] ? -d : d;
  endfunction

  // Classify the incoming item
  always_comb begin
    wr_item.d_mean    = absdiff(in_item.first_mean, in_item.second_mean);
    wr_item.d_kone    = absdiff(in_item.first_kone, in_item.second_kone);
    wr_item.d_ktwo    = absdiff(in_item.first_ktwo, in_item.second_ktwo);
    wr_item.mode      = mode;
    wr_item.last_item = in_item.last_item;
  end

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = fifo[rptr];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= wr_item;
  end

endmodule

// ===== hdl/ena_back.sv =====
// Back end: accumulates queued items, then finishes a run with an
// iterative square root and divider as the mode requires. Depends on ena_pkg.
module ena_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  ena_pkg::work_t     q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ena_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {ACCUM, SQRT, DIV, EMIT} state_t;

  state_t            state;
  logic [63:0]       acc [3];
  logic [16:0]       items_seen;
  logic [2:0]        fmode;
  logic [1:0]        ch;
  logic [5:0]        step;
  logic [63:0]       rem, root, sbit, quo;
  logic [31:0]       res [3];
  logic [64:0]       s;
  logic [64:0]       rtrial;
  logic [64:0]       shr;
  logic [32:0]       dv [3];
  logic [16:0]       cnt_next;
  logic              mode_ok;

  assign dv[0] = q_item.d_mean;
  assign dv[1] = q_item.d_kone;
  assign dv[2] = q_item.d_ktwo;
  assign mode_ok = (q_item.mode == ena_pkg::ModeL1) || (q_item.mode == ena_pkg::ModeL2)
                || (q_item.mode == ena_pkg::ModeLinf);
  assign q_ready = (state == ACCUM);
  assign cnt_next = (items_seen < ena_pkg::MaxPairs) ? items_seen + 17'd1 : items_seen;

  // Accumulate one channel in the selected form; a difference fits in 32 bits
  function automatic logic [63:0] accum(logic [63:0] a, logic [32:0] d, logic [2:0] m);
    logic [63:0] p;
    logic [64:0] sm;
    p = 64'(d[31:0]) * 64'(d[31:0]);
    case (m)
      ena_pkg::ModeL1: begin
        sm = 65'(a) + 65'(d);
        return sm[64] ? '1 : sm[63:0];
      end
      ena_pkg::ModeL2: begin
        sm = 65'(a) + 65'(p);
        return sm[64] ? '1 : sm[63:0];
      end
      ena_pkg::ModeLinf: return (64'(d) > a) ? 64'(d) : a;
      default: return a;
    endcase
  endfunction

  // Restoring division step: remainder/shift of dividend
  assign shr    = {rem, quo[63]};
  assign s      = shr - 65'(items_seen);
  assign rtrial = 65'(root) + 65'(sbit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ACCUM;
      items_seen <= '0;
      out_valid  <= 1'b0;
      step       <= '0;
      sbit       <= '0;
      for (int i = 0; i < 3; i++) acc[i] <= '0;
    end else begin
      case (state)
        ACCUM: begin
          if (q_valid) begin
            for (int i = 0; i < 3; i++) acc[i] <= accum(acc[i], dv[i], q_item.mode);
            items_seen <= cnt_next;
            if (q_item.last_item) begin
              fmode <= mode_ok ? q_item.mode : ena_pkg::ModeInvalid;
              ch    <= 2'd0;
              state <= SQRT;
            end
          end
        end
        SQRT: begin
          // Start a channel: L2 takes a root first, L1 divides, Linf passes, other modes give zero
          if (step == 6'd0 && fmode == ena_pkg::ModeL2 && sbit == 64'd0) begin
            rem  <= acc[ch];
            root <= '0;
            sbit <= 64'h4000_0000_0000_0000;
            step <= 6'd1;
          end else if (fmode == ena_pkg::ModeL2 && step != 6'd0) begin
            if (sbit == 64'd0) begin
              quo   <= root;
              rem   <= '0;
              step  <= 6'd0;
              state <= DIV;
            end else begin
              if (65'(rem) >= rtrial) begin
                rem  <= rem - rtrial[63:0];
                root <= (root >> 1) + sbit;
              end else begin
                root <= root >> 1;
              end
              sbit <= sbit >> 2;
            end
          end else if (fmode == ena_pkg::ModeL1) begin
            quo   <= acc[ch];
            rem   <= '0;
            step  <= 6'd0;
            state <= DIV;
          end else begin
            res[ch] <= (fmode == ena_pkg::ModeLinf)
                       ? ((acc[ch] > 64'hFFFF_FFFF) ? '1 : acc[ch][31:0]) : '0;
            sbit <= '0;
            if (ch == 2'd2) state <= EMIT;
            else ch <= ch + 2'd1;
          end
        end
        DIV: begin
          // One quotient bit a cycle, for a 64-bit quotient
          if (!s[64]) rem <= s[63:0];
          else        rem <= shr[63:0];
          quo  <= {quo[62:0], !s[64]};
          step <= step + 6'd1;
          if (step == 6'd63) begin
            res[ch] <= ({quo[62:0], !s[64]} > 64'hFFFF_FFFF) ? '1 : {quo[30:0], !s[64]};
            sbit <= '0;
            if (ch == 2'd2) state <= EMIT;
            else begin
              ch    <= ch + 2'd1;
              state <= SQRT;
            end
          end
        end
        EMIT: begin
          if (!out_valid) begin
            out_item.mean_error <= res[0];
            out_item.kone_error <= res[1];
            out_item.ktwo_error <= res[2];
            out_item.pair_count <= items_seen;
            out_item.status     <= (fmode == ena_pkg::ModeInvalid);
            out_valid           <= 1'b1;
            items_seen          <= '0;
            for (int i = 0; i < 3; i++) acc[i] <= '0;
            state <= ACCUM;
          end
        end
        default: state <= ACCUM;
      endcase
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== hdl/error_norm_accumulator.sv =====
// Error norm accumulator: L1, L2 or L-infinity error over curvature pairs.
// Throughput: one item per cycle while the back end accumulates; an item is queued, then accumulated.
// A last item raises out_valid once all three channels are finished in turn by one shared
// root/divide unit (L1 divides, L2 takes a root then divides), if no result waits.
// Reset (rst, synchronous) clears accumulators, count, queue; mode becomes 3.
// Depends on ena_pkg, ena_front, ena_back.
module error_norm_accumulator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ena_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ena_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);

  logic [2:0]     error_mode;
  logic           q_valid, q_ready;
  ena_pkg::work_t q_item;

  assign cfg_ready = 1'b1;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) error_mode <= ena_pkg::ModeLinf;
    else if (cfg_valid) error_mode <= cfg_data;
  end

  ena_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .mode(error_mode), .q_valid, .q_ready, .q_item
  );

  ena_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_item
  );

endmodule

// ===== hdl/ena_checker.sv =====
// Port-level checker for the error norm accumulator, bound to the top level.
// Depends on ena_pkg.
module ena_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input ena_pkg::out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result dropped while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.pair_count != 17'd0)
    else $error("zero pair count");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |-> out_item.mean_error == 32'd0
      && out_item.kone_error == 32'd0 && out_item.ktwo_error == 32'd0)
    else $error("invalid mode result not zero");

endmodule

bind error_norm_accumulator ena_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .out_item
);
